[rtl/core/dvd_ifo_header_stream_parser_macros.svh]
// Assertion helpers for the title set header parser.
`ifndef DVD_IFO_HEADER_STREAM_PARSER_MACROS_SVH
`define DVD_IFO_HEADER_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define DIFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define DIFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/difp_pkg.sv]
package difp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [8:0]  stream_id;
    logic [9:0]  width;
    logic [9:0]  height;
    logic [1:0]  aspect_kind;
    logic [3:0]  channels;
    logic        impaired;
    logic        commentary;
    logic        forced;
    logic        has_language;
    logic [15:0] language;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VIDEO,
    ST_AUDIO,
    ST_SUB
  } difp_state_t;

  localparam logic [2:0] KIND_VIDEO = 3'd0;
  localparam logic [2:0] KIND_AUDIO = 3'd1;
  localparam logic [2:0] KIND_SUB   = 3'd2;
  localparam logic [2:0] KIND_BAD   = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  localparam logic [9:0] OFS_SIG_END = 10'd12;
  localparam logic [9:0] OFS_VIDEO   = 10'h200;
  localparam logic [9:0] OFS_ACOUNT  = 10'h202;
  localparam logic [9:0] OFS_AENTRY  = 10'h204;
  localparam logic [9:0] OFS_SCOUNT  = 10'h254;
  localparam logic [9:0] OFS_SENTRY  = 10'h256;

  localparam logic [7:0] SIG_TEXT [12] = '{
    8'h44, 8'h56, 8'h44, 8'h56, 8'h49, 8'h44,
    8'h45, 8'h4F, 8'h2D, 8'h56, 8'h54, 8'h53
  };

  localparam logic [8:0] VIDEO_ID    = 9'h1E0;
  localparam logic [7:0] SUB_ID_BASE = 8'h20;

  localparam logic [2:0] AMODE_AC3   = 3'd0;
  localparam logic [2:0] AMODE_MPEG1 = 3'd2;
  localparam logic [2:0] AMODE_MPEG2 = 3'd3;
  localparam logic [2:0] AMODE_LPCM  = 3'd4;
  localparam logic [2:0] AMODE_DTS   = 3'd6;

  localparam logic [7:0] AID_AC3   = 8'h80;
  localparam logic [7:0] AID_MPEG1 = 8'hC0;
  localparam logic [7:0] AID_MPEG2 = 8'hC8;
  localparam logic [7:0] AID_LPCM  = 8'hA0;
  localparam logic [7:0] AID_DTS   = 8'h88;

  localparam logic [9:0] W_FULL  = 10'd720;
  localparam logic [9:0] W_CROP  = 10'd704;
  localparam logic [9:0] W_HALF  = 10'd352;
  localparam logic [9:0] H_NTSC  = 10'd480;
  localparam logic [9:0] H_NTSCF = 10'd240;
  localparam logic [9:0] H_PAL   = 10'd576;
  localparam logic [9:0] H_PALF  = 10'd288;

  localparam int AUD_LANES = 5;
  localparam int SUB_LANES = 4;

endpackage

[rtl/core/difp_ram.sv]
module difp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dvd_ifo_header_stream_parser.sv]
// Title set header parser. Takes one header byte per clock while busy is low.
// A bad-signature or truncated-header error comes out in the cycle after the
// byte that causes it, and busy stays low. On a good final header byte,
// busy is high while the video descriptor and the audio and subpicture
// entries are read out of the entry memories, one entry per cycle through
// their single read port; the results follow back to back, one per cycle,
// through the state and output registers. Results are strobed by out_valid
// for a single cycle and cannot be held off by the receiver.
module dvd_ifo_header_stream_parser #(
  parameter int HEADER_BYTES   = 984,
  parameter int MAX_AUDIO      = 8,
  parameter int MAX_SUBPICTURE = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  difp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output difp_pkg::out_item_t  out_item
);
  import difp_pkg::*;

  localparam int AW  = (MAX_AUDIO > 1) ? $clog2(MAX_AUDIO) : 1;
  localparam int SW  = (MAX_SUBPICTURE > 1) ? $clog2(MAX_SUBPICTURE) : 1;
  localparam int IW  = (AW > SW) ? AW : SW;
  localparam int ACW = $clog2(MAX_AUDIO + 1);
  localparam int SCW = $clog2(MAX_SUBPICTURE + 1);
  localparam logic [9:0] HB_END  = 10'(HEADER_BYTES);
  localparam logic [9:0] HB_LAST = 10'(HEADER_BYTES - 1);
  localparam logic [9:0] AUD_END = 10'(32'h204 + 8 * MAX_AUDIO);
  localparam logic [9:0] SP_END  = 10'(32'h256 + 6 * MAX_SUBPICTURE);

  difp_state_t state_r, state_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic           pend_r;
  logic           run_done;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_item_r, out_item_nxt;

  logic [9:0]     offset_r;
  logic           sig_ok_r;
  logic [15:0]    video_r;
  logic [7:0]     cnt_hi_r;
  logic [ACW-1:0] aud_cnt_r;
  logic [SCW-1:0] sp_cnt_r;
  logic [2:0]     sp_phase_r;
  logic [SW-1:0]  sp_idx_r;

  logic           accept, store, is_final, rearm;
  logic           in_aud, in_sp;
  logic [9:0]     arel;
  logic [7:0]     b;
  logic [AUD_LANES-1:0] aud_we;
  logic [SUB_LANES-1:0] sp_we;
  logic [AW-1:0]  aud_raddr;
  logic [SW-1:0]  sp_raddr;
  logic [AUD_LANES-1:0][7:0] aud_rd;
  logic [SUB_LANES-1:0][7:0] sp_rd;

  logic [1:0]  vstd, var_code;
  logic [2:0]  vres;
  logic [9:0]  vid_w, vid_h;
  logic [1:0]  vid_aspect;
  logic [7:0]  abase;
  logic [8:0]  aud_id;
  logic        aud_hl, sp_hl, aud_last, sp_last;
  logic [7:0]  aty, sty;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign b         = in_item.data_byte;
  assign store     = accept && (offset_r < HB_END);
  assign is_final  = (offset_r == HB_LAST);
  assign in_aud    = (offset_r >= OFS_AENTRY) && (offset_r < AUD_END);
  assign in_sp     = (offset_r >= OFS_SENTRY) && (offset_r < SP_END);
  assign arel      = offset_r - OFS_AENTRY;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign rearm = (accept && in_item.end_of_data && !(store && is_final && sig_ok_r))
              || (run_done && pend_r);

  // entry stores, one byte lane per kept byte
  always_comb begin
    aud_we = '0;
    if (store && in_aud) begin
      case (arel[2:0])
        3'd0:    aud_we[0] = 1'b1;
        3'd1:    aud_we[1] = 1'b1;
        3'd2:    aud_we[2] = 1'b1;
        3'd3:    aud_we[3] = 1'b1;
        3'd5:    aud_we[4] = 1'b1;
        default: aud_we = '0;
      endcase
    end
  end

  always_comb begin
    sp_we = '0;
    if (store && in_sp) begin
      case (sp_phase_r)
        3'd0:    sp_we[0] = 1'b1;
        3'd2:    sp_we[1] = 1'b1;
        3'd3:    sp_we[2] = 1'b1;
        3'd5:    sp_we[3] = 1'b1;
        default: sp_we = '0;
      endcase
    end
  end

  assign aud_raddr = (state_r == ST_AUDIO) ? AW'(idx_r[AW-1:0] + 1'b1) : '0;
  assign sp_raddr  = (state_r == ST_SUB) ? SW'(idx_r[SW-1:0] + 1'b1) : '0;

  for (genvar l = 0; l < AUD_LANES; l++) begin : g_aud
    difp_ram #(.WIDTH(8), .DEPTH(MAX_AUDIO)) u_ram (
      .clk   (clk),
      .we    (aud_we[l]),
      .waddr (arel[3 +: AW]),
      .wdata (b),
      .raddr (aud_raddr),
      .rdata (aud_rd[l])
    );
  end

  for (genvar l = 0; l < SUB_LANES; l++) begin : g_sp
    difp_ram #(.WIDTH(8), .DEPTH(MAX_SUBPICTURE)) u_ram (
      .clk   (clk),
      .we    (sp_we[l]),
      .waddr (sp_idx_r),
      .wdata (b),
      .raddr (sp_raddr),
      .rdata (sp_rd[l])
    );
  end

  // header registers
  always_ff @(posedge clk) begin
    if (!rst_n || rearm) begin
      offset_r   <= '0;
      sig_ok_r   <= 1'b1;
      video_r    <= '0;
      cnt_hi_r   <= '0;
      aud_cnt_r  <= '0;
      sp_cnt_r   <= '0;
      sp_phase_r <= '0;
      sp_idx_r   <= '0;
    end else if (store) begin
      offset_r <= offset_r + 1'b1;
      if (offset_r < OFS_SIG_END) begin
        if (b != SIG_TEXT[offset_r[3:0]]) begin
          sig_ok_r <= 1'b0;
        end
      end
      if (offset_r == OFS_VIDEO) begin
        video_r[15:8] <= b;
      end
      if (offset_r == OFS_VIDEO + 10'd1) begin
        video_r[7:0] <= b;
      end
      if (offset_r == OFS_ACOUNT || offset_r == OFS_SCOUNT) begin
        cnt_hi_r <= b;
      end
      if (offset_r == OFS_ACOUNT + 10'd1) begin
        aud_cnt_r <= (cnt_hi_r != '0 || b > 8'(MAX_AUDIO)) ? ACW'(MAX_AUDIO) : ACW'(b);
      end
      if (offset_r == OFS_SCOUNT + 10'd1) begin
        sp_cnt_r <= (cnt_hi_r != '0 || b > 8'(MAX_SUBPICTURE)) ?
                    SCW'(MAX_SUBPICTURE) : SCW'(b);
      end
      if (in_sp) begin
        if (sp_phase_r == 3'd5) begin
          sp_phase_r <= '0;
          sp_idx_r   <= sp_idx_r + 1'b1;
        end else begin
          sp_phase_r <= sp_phase_r + 3'd1;
        end
      end
    end
  end

  // descriptor decode
  assign vstd     = video_r[13:12];
  assign var_code = video_r[11:10];
  assign vres     = video_r[5:3];

  always_comb begin
    vid_w = '0;
    vid_h = '0;
    if (!vres[2] && (vstd == 2'd0 || vstd == 2'd1)) begin
      case (vres[1:0])
        2'd0:    vid_w = W_FULL;
        2'd1:    vid_w = W_CROP;
        default: vid_w = W_HALF;
      endcase
      if (vstd == 2'd0) begin
        vid_h = (vres[1:0] == 2'd3) ? H_NTSCF : H_NTSC;
      end else begin
        vid_h = (vres[1:0] == 2'd3) ? H_PALF : H_PAL;
      end
    end
    case (var_code)
      2'd0:    vid_aspect = 2'd0;
      2'd3:    vid_aspect = 2'd1;
      default: vid_aspect = 2'd2;
    endcase
  end

  always_comb begin
    case (aud_rd[0][7:5])
      AMODE_AC3:   abase = AID_AC3;
      AMODE_MPEG1: abase = AID_MPEG1;
      AMODE_MPEG2: abase = AID_MPEG2;
      AMODE_LPCM:  abase = AID_LPCM;
      AMODE_DTS:   abase = AID_DTS;
      default:     abase = '0;
    endcase
  end

  assign aud_id   = (abase == '0) ? '0 : 9'(abase) + 9'(idx_r[AW-1:0]);
  assign aud_hl   = (aud_rd[0][3:2] == 2'b01);
  assign sp_hl    = (sp_rd[0][1:0] == 2'b01);
  assign aty      = aud_rd[4];
  assign sty      = sp_rd[3];
  assign aud_last = (7'(idx_r) + 7'd1 == 7'(aud_cnt_r));
  assign sp_last  = (7'(idx_r) + 7'd1 == 7'(sp_cnt_r));

  // run sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    run_done      = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (store) begin
          if (is_final) begin
            if (!sig_ok_r) begin
              out_valid_nxt            = 1'b1;
              out_item_nxt.kind        = KIND_BAD;
              out_item_nxt.last_of_run = 1'b1;
            end else begin
              state_nxt = ST_VIDEO;
            end
          end else if (in_item.end_of_data) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.kind        = KIND_TRUNC;
            out_item_nxt.last_of_run = 1'b1;
          end
        end
      end
      ST_VIDEO: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.kind        = KIND_VIDEO;
        out_item_nxt.stream_id   = VIDEO_ID;
        out_item_nxt.width       = vid_w;
        out_item_nxt.height      = vid_h;
        out_item_nxt.aspect_kind = vid_aspect;
        idx_nxt                  = '0;
        if (aud_cnt_r != '0) begin
          state_nxt = ST_AUDIO;
        end else if (sp_cnt_r != '0) begin
          state_nxt = ST_SUB;
        end else begin
          state_nxt                = ST_IDLE;
          run_done                 = 1'b1;
          out_item_nxt.last_of_run = 1'b1;
        end
      end
      ST_AUDIO: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.kind         = KIND_AUDIO;
        out_item_nxt.stream_id    = aud_id;
        out_item_nxt.channels     = 4'(aud_rd[1][2:0]) + 4'd1;
        out_item_nxt.impaired     = (aty == 8'd2);
        out_item_nxt.commentary   = (aty == 8'd3) || (aty == 8'd4);
        out_item_nxt.has_language = aud_hl;
        out_item_nxt.language     = aud_hl ? {aud_rd[2], aud_rd[3]} : '0;
        idx_nxt                   = IW'(idx_r + 1'b1);
        if (aud_last) begin
          idx_nxt = '0;
          if (sp_cnt_r != '0) begin
            state_nxt = ST_SUB;
          end else begin
            state_nxt                = ST_IDLE;
            run_done                 = 1'b1;
            out_item_nxt.last_of_run = 1'b1;
          end
        end
      end
      ST_SUB: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.kind         = KIND_SUB;
        out_item_nxt.stream_id    = 9'(SUB_ID_BASE) + 9'(idx_r[SW-1:0]);
        out_item_nxt.impaired     = (sty >= 8'd1) && (sty <= 8'd7);
        out_item_nxt.commentary   = (sty >= 8'd13) && (sty <= 8'd15);
        out_item_nxt.forced       = (sty == 8'd9);
        out_item_nxt.has_language = sp_hl;
        out_item_nxt.language     = sp_hl ? {sp_rd[1], sp_rd[2]} : '0;
        idx_nxt                   = IW'(idx_r + 1'b1);
        if (sp_last) begin
          idx_nxt                  = '0;
          state_nxt                = ST_IDLE;
          run_done                 = 1'b1;
          out_item_nxt.last_of_run = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (store && is_final && sig_ok_r && in_item.end_of_data) begin
        pend_r <= 1'b1;
      end else if (run_done) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

[rtl/core/difp_checker.sv]
`include "dvd_ifo_header_stream_parser_macros.svh"

module difp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input difp_pkg::out_item_t out_item
);
  import difp_pkg::*;

  logic is_err, is_video, is_audio, run_item;

  assign is_err   = (out_item.kind == KIND_BAD) || (out_item.kind == KIND_TRUNC);
  assign is_video = (out_item.kind == KIND_VIDEO);
  assign is_audio = (out_item.kind == KIND_AUDIO);
  assign run_item = out_valid && (is_video || is_audio);

  // a run has no gaps
  `DIFP_ASSERT_NEXT(a_run_unbroken, out_valid && !out_item.last_of_run, out_valid, "run broken")

  `DIFP_ASSERT_NOW(a_err_last, out_valid && is_err, out_item.last_of_run, "error not last")

  `DIFP_ASSERT_NOW(a_video_busy, out_valid && is_video, $past(busy), "video outside run")

  `DIFP_ASSERT_NOW(a_audio_order, out_valid && is_audio, $past(run_item), "audio out of order")

  // a run starts only from an accepted item
  `DIFP_ASSERT_NEXT(a_busy_from_start, !busy && !start, !busy, "busy without start")

endmodule

bind dvd_ifo_header_stream_parser difp_checker u_difp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[tb/sv/dvd_ifo_header_stream_parser_checker.sv]
module dvd_ifo_header_stream_parser_checker #(
  parameter int HEADER_BYTES   = 984,
  parameter int MAX_AUDIO      = 8,
  parameter int MAX_SUBPICTURE = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  difp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  difp_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);
  import difp_pkg::*;

  localparam logic [1:0] STD_NTSC      = 2'd0;
  localparam logic [1:0] STD_PAL       = 2'd1;
  localparam logic [1:0] AR_CODE_4_3   = 2'd0;
  localparam logic [1:0] AR_CODE_16_9  = 2'd3;
  localparam logic [1:0] ASPECT_4_3    = 2'd0;
  localparam logic [1:0] ASPECT_16_9   = 2'd1;
  localparam logic [1:0] ASPECT_SQUARE = 2'd2;
  localparam logic [2:0] RES_720       = 3'd0;
  localparam logic [2:0] RES_704       = 3'd1;
  localparam logic [2:0] RES_352_HALF  = 3'd3;

  localparam logic [7:0] ATYPE_IMPAIRED = 8'd2;
  localparam logic [7:0] ATYPE_COMMENT  = 8'd3;
  localparam logic [7:0] ATYPE_DIRECTOR = 8'd4;
  localparam logic [7:0] STYPE_IMP_LO   = 8'd1;
  localparam logic [7:0] STYPE_IMP_HI   = 8'd7;
  localparam logic [7:0] STYPE_FORCED   = 8'd9;
  localparam logic [7:0] STYPE_COM_LO   = 8'd13;
  localparam logic [7:0] STYPE_COM_HI   = 8'd15;

  localparam logic [7:0] AUD_LANG_MASK = 8'h0C;
  localparam logic [7:0] AUD_LANG_SET  = 8'h04;
  localparam logic [7:0] SUB_LANG_MASK = 8'h03;
  localparam logic [7:0] SUB_LANG_SET  = 8'h01;

  logic [9:0]  hdr_ofs;
  bit          sig_ok;
  logic [15:0] video_attr;
  logic [7:0]  count_hi;
  int unsigned audio_cnt;
  int unsigned sub_cnt;
  logic [39:0] audio_attr [MAX_AUDIO];
  logic [31:0] sub_attr [MAX_SUBPICTURE];
  out_item_t   expected_descs [$];

  function automatic void rearm();
    hdr_ofs = '0;
    sig_ok = 1'b1;
    video_attr = '0;
    count_hi = '0;
    audio_cnt = 0;
    sub_cnt = 0;
  endfunction

  function automatic void push_desc(out_item_t d, bit last);
    d.last_of_run = last;
    expected_descs.push_back(d);
  endfunction

  function automatic void store_byte(int unsigned off, logic [7:0] b);
    int unsigned idx;
    int unsigned k;
    if (off < OFS_SIG_END) begin
      if (b != SIG_TEXT[off]) sig_ok = 1'b0;
    end else if (off == OFS_VIDEO) begin
      video_attr[15:8] = b;
    end else if (off == OFS_VIDEO + 1) begin
      video_attr[7:0] = b;
    end else if (off == OFS_ACOUNT || off == OFS_SCOUNT) begin
      count_hi = b;
    end else if (off == OFS_ACOUNT + 1) begin
      audio_cnt = (count_hi != 0 || b > MAX_AUDIO) ? MAX_AUDIO : b;
    end else if (off == OFS_SCOUNT + 1) begin
      sub_cnt = (count_hi != 0 || b > MAX_SUBPICTURE) ? MAX_SUBPICTURE : b;
    end else if (off >= OFS_AENTRY && off < OFS_AENTRY + 8 * MAX_AUDIO) begin
      idx = (off - OFS_AENTRY) / 8;
      k = (off - OFS_AENTRY) % 8;
      if (k <= 3) audio_attr[idx][k*8 +: 8] = b;
      else if (k == 5) audio_attr[idx][32 +: 8] = b;
    end else if (off >= OFS_SENTRY && off < OFS_SENTRY + 6 * MAX_SUBPICTURE) begin
      idx = (off - OFS_SENTRY) / 6;
      k = (off - OFS_SENTRY) % 6;
      case (k)
        0: sub_attr[idx][7:0] = b;
        2: sub_attr[idx][15:8] = b;
        3: sub_attr[idx][23:16] = b;
        5: sub_attr[idx][31:24] = b;
        default: ;
      endcase
    end
  endfunction

  function automatic void emit_descriptors();
    out_item_t   d;
    logic [1:0]  vstd;
    logic [1:0]  vaspect;
    logic [2:0]  vres;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  ty;
    logic [31:0] e;
    int unsigned total;
    d = '0;
    if (!sig_ok) begin
      d.kind = KIND_BAD;
      push_desc(d, 1'b1);
      return;
    end
    vstd = video_attr[13:12];
    vaspect = video_attr[11:10];
    vres = video_attr[5:3];
    total = 1 + audio_cnt + sub_cnt;
    d.kind = KIND_VIDEO;
    d.stream_id = VIDEO_ID;
    if ((vstd == STD_NTSC || vstd == STD_PAL) && vres <= RES_352_HALF) begin
      d.width = (vres == RES_720) ? W_FULL : (vres == RES_704) ? W_CROP : W_HALF;
      if (vstd == STD_NTSC) d.height = (vres == RES_352_HALF) ? H_NTSCF : H_NTSC;
      else d.height = (vres == RES_352_HALF) ? H_PALF : H_PAL;
    end
    d.aspect_kind = (vaspect == AR_CODE_4_3) ? ASPECT_4_3 :
                    (vaspect == AR_CODE_16_9) ? ASPECT_16_9 : ASPECT_SQUARE;
    push_desc(d, total == 1);

    for (int unsigned i = 0; i < audio_cnt; i++) begin
      a0 = audio_attr[i][7:0];
      a1 = audio_attr[i][15:8];
      ty = audio_attr[i][39:32];
      d = '0;
      d.kind = KIND_AUDIO;
      case (a0[7:5])
        AMODE_AC3:   d.stream_id = 9'(AID_AC3) + 9'(i);
        AMODE_MPEG1: d.stream_id = 9'(AID_MPEG1) + 9'(i);
        AMODE_MPEG2: d.stream_id = 9'(AID_MPEG2) + 9'(i);
        AMODE_LPCM:  d.stream_id = 9'(AID_LPCM) + 9'(i);
        AMODE_DTS:   d.stream_id = 9'(AID_DTS) + 9'(i);
        default:     d.stream_id = '0;
      endcase
      d.channels = {1'b0, a1[2:0]} + 4'd1;
      d.impaired = (ty == ATYPE_IMPAIRED);
      d.commentary = (ty == ATYPE_COMMENT || ty == ATYPE_DIRECTOR);
      d.has_language = (a0 & AUD_LANG_MASK) == AUD_LANG_SET;
      if (d.has_language) d.language = {audio_attr[i][23:16], audio_attr[i][31:24]};
      push_desc(d, i + 2 == total);
    end

    for (int unsigned i = 0; i < sub_cnt; i++) begin
      e = sub_attr[i];
      ty = e[31:24];
      d = '0;
      d.kind = KIND_SUB;
      d.stream_id = 9'(SUB_ID_BASE) + 9'(i);
      d.impaired = (ty >= STYPE_IMP_LO && ty <= STYPE_IMP_HI);
      d.commentary = (ty >= STYPE_COM_LO && ty <= STYPE_COM_HI);
      d.forced = (ty == STYPE_FORCED);
      d.has_language = (e[7:0] & SUB_LANG_MASK) == SUB_LANG_SET;
      if (d.has_language) d.language = {e[15:8], e[23:16]};
      push_desc(d, 2 + audio_cnt + i == total);
    end
  endfunction

  function automatic void track_byte(in_item_t it);
    out_item_t d;
    if (hdr_ofs < HEADER_BYTES) begin
      store_byte(hdr_ofs, it.data_byte);
      if (hdr_ofs == HEADER_BYTES - 1) begin
        emit_descriptors();
      end else if (it.end_of_data) begin
        d = '0;
        d.kind = KIND_TRUNC;
        push_desc(d, 1'b1);
      end
      hdr_ofs = hdr_ofs + 10'd1;
    end
    if (it.end_of_data) rearm();
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rearm();
      foreach (audio_attr[i]) audio_attr[i] = '0;
      foreach (sub_attr[i]) sub_attr[i] = '0;
    end else begin
      if (out_valid) begin
        if (expected_descs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          fail_count++;
        end else begin
          want = expected_descs.pop_front();
          check_field("kind", want.kind, out_item.kind);
          check_field("stream_id", want.stream_id, out_item.stream_id);
          check_field("width", want.width, out_item.width);
          check_field("height", want.height, out_item.height);
          check_field("aspect_kind", want.aspect_kind, out_item.aspect_kind);
          check_field("channels", want.channels, out_item.channels);
          check_field("impaired", want.impaired, out_item.impaired);
          check_field("commentary", want.commentary, out_item.commentary);
          check_field("forced", want.forced, out_item.forced);
          check_field("has_language", want.has_language, out_item.has_language);
          check_field("language", want.language, out_item.language);
          check_field("last_of_run", want.last_of_run, out_item.last_of_run);
        end
      end
      if (start && !busy) track_byte(in_item);
    end
    pending <= expected_descs.size();
  end

endmodule

[tb/sv/dvd_ifo_header_stream_parser_tb.sv]
module dvd_ifo_header_stream_parser_tb;
  import difp_pkg::*;

  localparam int HDR_BYTES = 984;
  localparam int MAX_AUD   = 8;
  localparam int MAX_SUB   = 32;

  // count field choices
  localparam int CNT_ZERO = 0;
  localparam int CNT_MAX  = 1;
  localparam int CNT_OVER = 2;
  localparam int CNT_HIGH = 3;
  localparam int CNT_SOME = 4;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  int         fail_count;
  int         pending;
  bit         steady;
  logic [7:0] hdr [HDR_BYTES];

  always begin
    clk = 1'b0;
    #6 clk = 1'b1;
    #6;
  end

  dvd_ifo_header_stream_parser #(
    .HEADER_BYTES(HDR_BYTES),
    .MAX_AUDIO(MAX_AUD),
    .MAX_SUBPICTURE(MAX_SUB)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  dvd_ifo_header_stream_parser_checker #(
    .HEADER_BYTES(HDR_BYTES),
    .MAX_AUDIO(MAX_AUD),
    .MAX_SUBPICTURE(MAX_SUB)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .fail_count(fail_count),
    .pending(pending)
  );

  function automatic logic [15:0] count_bytes(int sel, int max);
    case (sel)
      CNT_ZERO: return 16'd0;
      CNT_MAX:  return 16'(max);
      CNT_OVER: return {8'd0, 8'($urandom_range(255, max + 1))};
      CNT_HIGH: return {8'($urandom_range(255, 1)), 8'($urandom)};
      default:  return {8'd0, 8'($urandom_range(max, 1))};
    endcase
  endfunction

  task automatic build_header(input bit sig_bad, input int a_sel, input int s_sel);
    int          pos;
    logic [15:0] cnt;
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    foreach (SIG_TEXT[i]) hdr[i] = SIG_TEXT[i];
    if (sig_bad) begin
      pos = $urandom_range(11);
      hdr[pos] = SIG_TEXT[pos] ^ 8'($urandom_range(255, 1));
    end
    // favor NTSC/PAL and known resolutions
    if ($urandom_range(99) < 70) hdr[OFS_VIDEO][5] = 1'b0;
    if ($urandom_range(99) < 70) hdr[OFS_VIDEO + 1][5:3] = 3'($urandom_range(3));
    cnt = count_bytes(a_sel, MAX_AUD);
    hdr[OFS_ACOUNT] = cnt[15:8];
    hdr[OFS_ACOUNT + 1] = cnt[7:0];
    cnt = count_bytes(s_sel, MAX_SUB);
    hdr[OFS_SCOUNT] = cnt[15:8];
    hdr[OFS_SCOUNT + 1] = cnt[7:0];
    for (int i = 0; i < MAX_AUD; i++)
      if ($urandom_range(99) < 80) hdr[OFS_AENTRY + 8 * i + 5] = 8'($urandom_range(5));
    for (int i = 0; i < MAX_SUB; i++)
      if ($urandom_range(99) < 80) hdr[OFS_SENTRY + 6 * i + 5] = 8'($urandom_range(16));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eod);
    while (!steady && $urandom_range(99) < 34) begin
      @(negedge clk);
      start = 1'b0;
      in_item.data_byte = 8'($urandom);
      in_item.end_of_data = 1'($urandom);
    end
    @(negedge clk);
    start = 1'b1;
    in_item.data_byte = b;
    in_item.end_of_data = eod;
    do @(posedge clk); while (busy);
  endtask

  // n header bytes, then tail ignored bytes; end_of_data on the last one
  task automatic send_file(input int n, input int tail);
    for (int i = 0; i < n + tail; i++)
      send_byte(i < n ? hdr[i] : 8'($urandom), i == n + tail - 1);
  endtask

  initial begin
    #(12 * 500000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int len;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // early ends: first byte, bad signature, full good signature
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    foreach (SIG_TEXT[i]) send_byte(SIG_TEXT[i], i == 11);
    send_byte(SIG_TEXT[0], 1'b0);
    send_byte(8'h00, 1'b1);

    repeat (3) begin
      len = $urandom_range(40, 1);
      build_header($urandom_range(3) == 0, $urandom_range(CNT_SOME), $urandom_range(CNT_SOME));
      send_file(len, 0);
    end

    // one whole header, both counts clamped, end_of_data on its last byte
    steady = 1'b1;
    build_header(1'b0, CNT_HIGH, CNT_OVER);
    send_file(HDR_BYTES, 0);
    steady = 1'b0;

    repeat (2) begin
      len = $urandom_range(40, 1);
      build_header($urandom_range(3) == 0, $urandom_range(CNT_SOME), $urandom_range(CNT_SOME));
      send_file(len, 0);
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
